/* src/apt_pkg.sv */
`default_nettype none
package apt_pkg;
    localparam int unsigned TABLE_DEPTH = 64;
    localparam int unsigned ADDR_W = 48;
    localparam int unsigned STR_W = 8;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned WEIGHT_W = 15;
    localparam int unsigned INDEX_W = 31;
    localparam int unsigned LEVEL_W = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_TH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEAK_TH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECENT_WIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MED_FLOOR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MED_CEIL = 3'd6;

    localparam logic signed [STR_W-1:0] ACCEPT_TH_RST = -8'sd70;
    localparam logic signed [STR_W-1:0] WEAK_TH_RST = -8'sd60;
    localparam logic [TIME_W-1:0] AGE_LIMIT_RST = 32'd300000;
    localparam logic [TIME_W-1:0] RECENT_WIN_RST = 32'd30000;
    localparam logic [INDEX_W-1:0] MED_FLOOR_RST = 31'd9600;
    localparam logic [INDEX_W-1:0] MED_CEIL_RST = 31'd15600;
    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    localparam logic [LEVEL_W-1:0] LEVEL_LOW = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE,
        S_SCAN,
        S_MULT,
        S_ACCUM,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOOKUP,
        OP_SCAN
    } t_op;

    // command travelling along the chain, plus its running results
    typedef struct packed {
        t_op op;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] now;
        logic hit;
        logic free_found;
        logic [15:0] weak_cnt;
        logic [15:0] strong_cnt;
    } t_token;

    typedef struct packed {
        logic wr_hit;
        logic wr_ins;
        logic [ADDR_W-1:0] addr;
        logic signed [STR_W-1:0] strength;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] age_limit;
        logic [TIME_W-1:0] recent_win;
        logic signed [STR_W-1:0] weak_th;
    } t_ctl;
endpackage
`default_nettype wire

/* src/apt_cell.sv */
`default_nettype none
module apt_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire apt_pkg::t_ctl i_ctl,
    input  wire logic          i_sel_hit,
    input  wire logic          i_sel_ins,
    input  wire apt_pkg::t_token i_tok,
    output apt_pkg::t_token  o_tok,
    output logic             o_hit,
    output logic             o_free
);
    logic                                r_valid;
    logic [apt_pkg::ADDR_W-1:0]          r_addr;
    logic signed [apt_pkg::STR_W-1:0]    r_str;
    logic [apt_pkg::TIME_W-1:0]          r_seen;
    logic                                r_new;
    apt_pkg::t_token                     r_tok;
    apt_pkg::t_token                     n_tok;
    logic [apt_pkg::TIME_W-1:0]          age;

    assign o_hit  = r_valid && (r_addr == i_ctl.addr);
    assign o_free = !r_valid;
    assign age    = i_ctl.now - r_seen;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.op == apt_pkg::OP_LOOKUP) begin
            n_tok.hit = i_tok.hit | o_hit;
            n_tok.free_found = i_tok.free_found | o_free;
        end else if (i_tok.op == apt_pkg::OP_SCAN) begin
            if (r_valid && r_new && age < i_ctl.recent_win) begin
                if (r_str < i_ctl.weak_th) begin
                    n_tok.weak_cnt = i_tok.weak_cnt + 16'd1;
                end else begin
                    n_tok.strong_cnt = i_tok.strong_cnt + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok.op <= apt_pkg::OP_NONE;
        end else begin
            r_tok <= n_tok;
            if (i_ctl.wr_ins && i_sel_ins) begin
                r_valid <= 1'b1;
            end else if (i_tok.op == apt_pkg::OP_SCAN && r_valid
                         && age > i_ctl.age_limit) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_ins && i_sel_ins) begin
            r_addr <= i_ctl.addr;
            r_str  <= i_ctl.strength;
            r_seen <= i_ctl.now;
            r_new  <= 1'b1;
        end else if (i_ctl.wr_hit && i_sel_hit) begin
            r_seen <= i_ctl.now;
            r_new  <= 1'b0;
        end
    end

    assign o_tok = r_tok;
endmodule
`default_nettype wire

/* src/address_presence_table_with_aging.sv */
`default_nettype none
// Address presence table with aging.
// Config: write i_cfg_we with i_cfg_index (register order) and i_cfg_data while idle.
// Items: pulse start while busy is low with address, strength and timestamp.
// One result per item: o_done strobes for one cycle with accepted, inserted,
// table_full, risk_index and risk_level; the receiver cannot stall.
// A rejected frame goes straight to the done state. An accepted frame passes a lookup
// token down the row of TABLE_DEPTH cells, then writes the hit or free entry. An
// insert then sends a scan token through the row that purges aged entries, and
// a second that counts recent new ones, then a multiply and an accumulate.
// busy is high from the accepting edge until o_done rises; the next item may be
// accepted in the o_done cycle.
// Reset clears all entries' valid bits, the index and the registers to defaults.
module address_presence_table_with_aging #(
    parameter int unsigned TABLE_DEPTH = apt_pkg::TABLE_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [apt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [apt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [apt_pkg::ADDR_W-1:0]        i_source_address,
    input  wire logic signed [apt_pkg::STR_W-1:0]  i_signal_strength,
    input  wire logic [apt_pkg::TIME_W-1:0]        i_now_ms,
    output logic                                   o_done,
    output logic                                   o_accepted,
    output logic                                   o_inserted,
    output logic                                   o_table_full,
    output logic [apt_pkg::INDEX_W-1:0]            o_risk_index,
    output logic [apt_pkg::LEVEL_W-1:0]            o_risk_level
);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 2);

    logic signed [apt_pkg::STR_W-1:0] r_acc_th, r_weak_th;
    logic [apt_pkg::TIME_W-1:0]       r_age_lim, r_recent;
    logic [apt_pkg::WEIGHT_W-1:0]     r_weight;
    logic [apt_pkg::INDEX_W-1:0]      r_floor, r_ceil, r_index;

    apt_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_pass;
    logic [apt_pkg::ADDR_W-1:0]       r_addr;
    logic signed [apt_pkg::STR_W-1:0] r_str;
    logic [apt_pkg::TIME_W-1:0]       r_now;
    logic r_acc, r_ins, r_full, r_hit;
    logic [15:0] r_weak, r_strong;
    logic [47:0] r_prod;
    logic r_done;

    apt_pkg::t_token tok [TABLE_DEPTH+1];
    apt_pkg::t_token tok_head;
    logic [TABLE_DEPTH-1:0] hit_v, free_v, sel_hit, sel_ins;
    apt_pkg::t_ctl ctl;

    always_comb begin
        tok_head = '0;
        tok_head.op = apt_pkg::OP_NONE;
        tok_head.addr = r_addr;
        tok_head.now = r_now;
        if (r_state == apt_pkg::S_LOOKUP && r_cnt == '0) begin
            tok_head.op = apt_pkg::OP_LOOKUP;
        end else if (r_state == apt_pkg::S_SCAN && r_cnt == '0) begin
            tok_head.op = apt_pkg::OP_SCAN;
        end
    end

    assign tok[0] = tok_head;

    assign ctl.wr_hit = (r_state == apt_pkg::S_UPDATE) && r_hit;
    assign ctl.wr_ins = (r_state == apt_pkg::S_UPDATE) && !r_hit && |free_v;
    assign ctl.addr = r_addr;
    assign ctl.strength = r_str;
    assign ctl.now = r_now;
    assign ctl.age_limit = r_age_lim;
    assign ctl.recent_win = r_recent;
    assign ctl.weak_th = r_weak_th;

    // lowest free and lowest hit, one-hot
    always_comb begin
        logic seen_h, seen_f;
        seen_h = 1'b0;
        seen_f = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            sel_hit[k] = hit_v[k] && !seen_h;
            sel_ins[k] = free_v[k] && !seen_f;
            seen_h = seen_h | hit_v[k];
            seen_f = seen_f | free_v[k];
        end
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        apt_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_sel_hit (sel_hit[g]),
            .i_sel_ins (sel_ins[g]),
            .i_tok     (tok[g]),
            .o_tok     (tok[g+1]),
            .o_hit     (hit_v[g]),
            .o_free    (free_v[g])
        );
    end

    logic last_tok;
    assign last_tok = r_cnt == CNT_W'(TABLE_DEPTH);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            apt_pkg::S_IDLE: begin
                if (start) begin
                    n_state = (i_signal_strength > r_acc_th) ? apt_pkg::S_LOOKUP
                                                             : apt_pkg::S_DONE;
                end
            end
            apt_pkg::S_LOOKUP: if (last_tok) n_state = apt_pkg::S_UPDATE;
            apt_pkg::S_UPDATE: n_state = (!r_hit && |free_v) ? apt_pkg::S_SCAN
                                                             : apt_pkg::S_DONE;
            apt_pkg::S_SCAN: if (last_tok && r_pass) n_state = apt_pkg::S_MULT;
            apt_pkg::S_MULT: n_state = apt_pkg::S_ACCUM;
            apt_pkg::S_ACCUM: n_state = apt_pkg::S_DONE;
            apt_pkg::S_DONE: n_state = apt_pkg::S_IDLE;
            default: n_state = apt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        busy = r_state != apt_pkg::S_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apt_pkg::S_IDLE;
            r_cnt <= '0;
            r_pass <= 1'b0;
            r_index <= '0;
            r_done <= 1'b0;
            r_acc_th <= apt_pkg::ACCEPT_TH_RST;
            r_weak_th <= apt_pkg::WEAK_TH_RST;
            r_age_lim <= apt_pkg::AGE_LIMIT_RST;
            r_recent <= apt_pkg::RECENT_WIN_RST;
            r_weight <= '0;
            r_floor <= apt_pkg::MED_FLOOR_RST;
            r_ceil <= apt_pkg::MED_CEIL_RST;
        end else begin
            r_state <= n_state;
            r_done <= r_state == apt_pkg::S_DONE;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    apt_pkg::REG_ACCEPT_TH:  r_acc_th <= i_cfg_data[apt_pkg::STR_W-1:0];
                    apt_pkg::REG_WEAK_TH:    r_weak_th <= i_cfg_data[apt_pkg::STR_W-1:0];
                    apt_pkg::REG_AGE_LIMIT:  r_age_lim <= i_cfg_data;
                    apt_pkg::REG_RECENT_WIN: r_recent <= i_cfg_data;
                    apt_pkg::REG_WEIGHT:     r_weight <= i_cfg_data[apt_pkg::WEIGHT_W-1:0];
                    apt_pkg::REG_MED_FLOOR:  r_floor <= i_cfg_data[apt_pkg::INDEX_W-1:0];
                    apt_pkg::REG_MED_CEIL:   r_ceil <= i_cfg_data[apt_pkg::INDEX_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == apt_pkg::S_LOOKUP || r_state == apt_pkg::S_SCAN) begin
                if (last_tok) begin
                    r_cnt <= '0;
                    r_pass <= ~r_pass;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end else begin
                r_cnt <= '0;
                r_pass <= 1'b0;
            end
            if (r_state == apt_pkg::S_ACCUM) begin
                r_index <= ({1'b0, r_index} + 32'(r_weak) + 32'(r_prod[47:8])
                            > {1'b0, apt_pkg::INDEX_MAX}
                            || |r_prod[47:39])
                           ? apt_pkg::INDEX_MAX
                           : r_index + apt_pkg::INDEX_W'(r_weak)
                             + r_prod[38:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == apt_pkg::S_IDLE && start) begin
            r_addr <= i_source_address;
            r_str <= i_signal_strength;
            r_now <= i_now_ms;
            r_acc <= i_signal_strength > r_acc_th;
            r_ins <= 1'b0;
            r_full <= 1'b0;
        end
        if (r_state == apt_pkg::S_LOOKUP && last_tok) begin
            r_hit <= tok[TABLE_DEPTH].hit;
        end
        if (r_state == apt_pkg::S_UPDATE) begin
            r_ins <= !r_hit && |free_v;
            r_full <= !r_hit && !(|free_v);
        end
        if (r_state == apt_pkg::S_SCAN && last_tok) begin
            r_weak <= tok[TABLE_DEPTH].weak_cnt;
            r_strong <= tok[TABLE_DEPTH].strong_cnt;
        end
        if (r_state == apt_pkg::S_MULT) begin
            r_prod <= 48'({r_strong, 1'b0}) * 48'(r_weight);
        end
    end

    assign o_done = r_done;
    assign o_accepted = r_acc;
    assign o_inserted = r_ins;
    assign o_table_full = r_full;
    assign o_risk_index = r_index;
    always_comb begin
        o_risk_level = apt_pkg::LEVEL_LOW;
        if (r_index >= r_floor && r_index <= r_ceil) o_risk_level = apt_pkg::LEVEL_MEDIUM;
        if (r_index > r_ceil) o_risk_level = apt_pkg::LEVEL_HIGH;
    end
endmodule
`default_nettype wire

/* src/apt_checker.sv */
`default_nettype none
module apt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_done,
    input wire logic       o_accepted,
    input wire logic       o_inserted,
    input wire logic       o_table_full,
    input wire logic [1:0] o_risk_level
);
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double strobe");
    a_ins_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_inserted && o_table_full)) else $error("insert and full");
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_inserted || o_table_full) |-> o_accepted) else $error("not accepted");
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_risk_level != 2'd3) else $error("bad level");
    a_idle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("not busy");
endmodule

bind address_presence_table_with_aging apt_checker u_apt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_done(o_done),
    .o_accepted(o_accepted), .o_inserted(o_inserted), .o_table_full(o_table_full),
    .o_risk_level(o_risk_level)
);
`default_nettype wire

/* tb/sv/tb_address_presence_table_with_aging.sv */
`default_nettype none
module tb_address_presence_table_with_aging;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int DRAIN_CYCLES = 3 * DEPTH + 40;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int N_PHASES = 9;
    localparam int ITEMS_PER_PHASE = 135;

    typedef struct packed {
        logic accepted;
        logic inserted;
        logic table_full;
        logic [apt_pkg::INDEX_W-1:0] risk_index;
        logic [apt_pkg::LEVEL_W-1:0] risk_level;
    } t_frame_result;

    typedef struct {
        logic [apt_pkg::ADDR_W-1:0] addr;
        logic signed [apt_pkg::STR_W-1:0] strength;
        logic [apt_pkg::TIME_W-1:0] now;
        bit typed;
        logic accepted;
        logic inserted;
        logic table_full;
    } t_frame_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [apt_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [apt_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    logic [apt_pkg::ADDR_W-1:0] i_source_address = '0;
    logic signed [apt_pkg::STR_W-1:0] i_signal_strength = '0;
    logic [apt_pkg::TIME_W-1:0] i_now_ms = '0;
    logic o_done;
    logic o_accepted;
    logic o_inserted;
    logic o_table_full;
    logic [apt_pkg::INDEX_W-1:0] o_risk_index;
    logic [apt_pkg::LEVEL_W-1:0] o_risk_level;

    address_presence_table_with_aging DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic signed [apt_pkg::STR_W-1:0] accept_th, weak_th;
    logic [apt_pkg::TIME_W-1:0] age_limit, recent_win;
    logic [apt_pkg::WEIGHT_W-1:0] weight;
    logic [apt_pkg::INDEX_W-1:0] med_floor, med_ceil;
    logic [apt_pkg::ADDR_W-1:0] addr_tab[DEPTH];
    logic signed [apt_pkg::STR_W-1:0] str_tab[DEPTH];
    logic [apt_pkg::TIME_W-1:0] seen_tab[DEPTH];
    bit new_tab[DEPTH];
    bit valid_tab[DEPTH];
    logic [apt_pkg::INDEX_W-1:0] risk_total;

    t_frame_result pending_results[$];
    int errors = 0;
    longint cycles = 0;

    function automatic logic [apt_pkg::LEVEL_W-1:0] level_for(
            logic [apt_pkg::INDEX_W-1:0] idx);
        if (idx > med_ceil) return apt_pkg::LEVEL_HIGH;
        if (idx >= med_floor) return apt_pkg::LEVEL_MEDIUM;
        return apt_pkg::LEVEL_LOW;
    endfunction

    function automatic t_frame_result score_frame(logic [apt_pkg::ADDR_W-1:0] addr,
                                                  logic signed [apt_pkg::STR_W-1:0] strength,
                                                  logic [apt_pkg::TIME_W-1:0] now);
        t_frame_result r;
        int hit, free_slot;
        longint cnt_weak, cnt_strong, sum;
        r = '0;
        if (strength > accept_th) begin
            r.accepted = 1'b1;
            hit = -1;
            free_slot = -1;
            for (int i = 0; i < DEPTH; i++) begin
                if (valid_tab[i]) begin
                    if (hit < 0 && addr_tab[i] == addr) hit = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (hit >= 0) begin
                seen_tab[hit] = now;
                new_tab[hit] = 0;
            end else if (free_slot < 0) begin
                r.table_full = 1'b1;
            end else begin
                r.inserted = 1'b1;
                addr_tab[free_slot] = addr;
                str_tab[free_slot] = strength;
                seen_tab[free_slot] = now;
                new_tab[free_slot] = 1;
                valid_tab[free_slot] = 1;
                for (int i = 0; i < DEPTH; i++)
                    if (valid_tab[i] && apt_pkg::TIME_W'(now - seen_tab[i]) > age_limit)
                        valid_tab[i] = 0;
                cnt_weak = 0;
                cnt_strong = 0;
                for (int i = 0; i < DEPTH; i++)
                    if (valid_tab[i] && new_tab[i]
                        && apt_pkg::TIME_W'(now - seen_tab[i]) < recent_win) begin
                        if (str_tab[i] < weak_th) cnt_weak++;
                        else cnt_strong++;
                    end
                sum = cnt_weak + ((2 * cnt_strong * longint'(weight)) >>> 8)
                      + longint'(risk_total);
                risk_total = (sum > longint'(apt_pkg::INDEX_MAX)) ? apt_pkg::INDEX_MAX
                                                                  : apt_pkg::INDEX_W'(sum);
            end
        end
        r.risk_index = risk_total;
        r.risk_level = level_for(risk_total);
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_frame_result w;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                w = pending_results.pop_front();
                if (o_accepted !== w.accepted) report("accepted", o_accepted, w.accepted);
                if (o_inserted !== w.inserted) report("inserted", o_inserted, w.inserted);
                if (o_table_full !== w.table_full)
                    report("table_full", o_table_full, w.table_full);
                if (o_risk_index !== w.risk_index)
                    report("risk_index", o_risk_index, w.risk_index);
                if (o_risk_level !== w.risk_level)
                    report("risk_level", o_risk_level, w.risk_level);
            end
        end
    end

    task automatic hold_start_low(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_frame(logic [apt_pkg::ADDR_W-1:0] addr,
                              logic signed [apt_pkg::STR_W-1:0] strength,
                              logic [apt_pkg::TIME_W-1:0] now, int gap,
                              output t_frame_result r);
        if (gap > 0) hold_start_low(gap);
        start <= 1'b1;
        i_source_address <= addr;
        i_signal_strength <= strength;
        i_now_ms <= now;
        do @(posedge i_clk); while (busy);
        r = score_frame(addr, strength, now);
        pending_results = {pending_results, r};
    endtask

    task automatic wait_idle();
        hold_start_low(1);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [apt_pkg::CFG_IDX_W-1:0] idx,
                             logic [apt_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            apt_pkg::REG_ACCEPT_TH: accept_th = data[apt_pkg::STR_W-1:0];
            apt_pkg::REG_WEAK_TH: weak_th = data[apt_pkg::STR_W-1:0];
            apt_pkg::REG_AGE_LIMIT: age_limit = data;
            apt_pkg::REG_RECENT_WIN: recent_win = data;
            apt_pkg::REG_WEIGHT: weight = data[apt_pkg::WEIGHT_W-1:0];
            apt_pkg::REG_MED_FLOOR: med_floor = data[apt_pkg::INDEX_W-1:0];
            apt_pkg::REG_MED_CEIL: med_ceil = data[apt_pkg::INDEX_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [apt_pkg::ADDR_W-1:0] rand_addr();
        return apt_pkg::ADDR_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [31:0] rand_time_span();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 50);
            1, 2: return $urandom_range(0, 3000);
            3: return $urandom_range(0, 400000);
            default: return $urandom();
        endcase
    endfunction

    t_frame_row frame_rows[12];

    initial begin
        t_frame_result r;
        logic [apt_pkg::ADDR_W-1:0] pool[$];
        logic [apt_pkg::TIME_W-1:0] clock_ms;
        int gap;

        frame_rows = '{
            '{48'h0, -8'sd70, 32'd0, 1, 1'b0, 1'b0, 1'b0},
            '{48'h0, -8'sd69, 32'd0, 1, 1'b1, 1'b1, 1'b0},
            '{48'h0, 8'sd127, 32'd5, 1, 1'b1, 1'b0, 1'b0},
            '{48'hFFFF_FFFF_FFFF, 8'sd127, 32'hFFFF_FFFF, 1, 1'b1, 1'b1, 1'b0},
            '{48'h0, -8'sd128, 32'd10, 1, 1'b0, 1'b0, 1'b0},
            '{48'hAAAA_AAAA_AAAA, 8'sd0, 32'd0, 1, 1'b1, 1'b1, 1'b0},
            '{48'h5555_5555_5555, -8'sd60, 32'd100, 1, 1'b1, 1'b1, 1'b0},
            '{48'h5555_5555_5555, 8'sd1, 32'd200, 1, 1'b1, 1'b0, 1'b0},
            '{48'h0000_0000_0001, -8'sd61, 32'd400000, 1, 1'b1, 1'b1, 1'b0},
            '{48'h0000_0000_0002, 8'sd50, 32'd400000, 0, 1'b0, 1'b0, 1'b0},
            '{48'hFFFF_FFFF_FFFF, -8'sd1, 32'd400010, 0, 1'b0, 1'b0, 1'b0},
            '{48'h8000_0000_0000, -8'sd50, 32'd429000, 0, 1'b0, 1'b0, 1'b0}
        };

        accept_th = apt_pkg::ACCEPT_TH_RST;
        weak_th = apt_pkg::WEAK_TH_RST;
        age_limit = apt_pkg::AGE_LIMIT_RST;
        recent_win = apt_pkg::RECENT_WIN_RST;
        weight = '0;
        med_floor = apt_pkg::MED_FLOOR_RST;
        med_ceil = apt_pkg::MED_CEIL_RST;
        risk_total = '0;
        foreach (valid_tab[i]) valid_tab[i] = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (frame_rows[k]) begin
            send_frame(frame_rows[k].addr, frame_rows[k].strength, frame_rows[k].now,
                       $urandom_range(0, 2), r);
            if (frame_rows[k].typed) begin
                if (r.accepted !== frame_rows[k].accepted)
                    report("row accepted", r.accepted, frame_rows[k].accepted);
                if (r.inserted !== frame_rows[k].inserted)
                    report("row inserted", r.inserted, frame_rows[k].inserted);
                if (r.table_full !== frame_rows[k].table_full)
                    report("row table_full", r.table_full, frame_rows[k].table_full);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin
                    write_reg(apt_pkg::REG_ACCEPT_TH, 32'hFFFF_FF80);
                    write_reg(apt_pkg::REG_WEAK_TH, 32'hFFFF_FF80);
                    write_reg(apt_pkg::REG_AGE_LIMIT, 32'd0);
                    write_reg(apt_pkg::REG_RECENT_WIN, 32'd0);
                    write_reg(apt_pkg::REG_WEIGHT, 32'd0);
                    write_reg(apt_pkg::REG_MED_FLOOR, 32'd0);
                    write_reg(apt_pkg::REG_MED_CEIL, 32'd0);
                end
                1: begin
                    write_reg(apt_pkg::REG_ACCEPT_TH, 32'd127);
                    write_reg(apt_pkg::REG_WEAK_TH, 32'd127);
                    write_reg(apt_pkg::REG_AGE_LIMIT, 32'hFFFF_FFFF);
                    write_reg(apt_pkg::REG_RECENT_WIN, 32'hFFFF_FFFF);
                    write_reg(apt_pkg::REG_WEIGHT, 32'd25600);
                    write_reg(apt_pkg::REG_MED_FLOOR, 32'h7FFF_FFFF);
                    write_reg(apt_pkg::REG_MED_CEIL, 32'h7FFF_FFFF);
                    write_reg(apt_pkg::REG_ACCEPT_TH, 32'hFFFF_FF80);
                end
                2: begin
                    write_reg(apt_pkg::REG_WEAK_TH, 32'd0);
                    write_reg(apt_pkg::REG_WEIGHT, 32'd25600);
                    write_reg(apt_pkg::REG_MED_FLOOR, 32'd200000);
                    write_reg(apt_pkg::REG_MED_CEIL, 32'd1000);
                end
                default: begin
                    write_reg(apt_pkg::REG_ACCEPT_TH,
                              32'(signed'(8'($urandom_range(128, 255)))));
                    write_reg(apt_pkg::REG_WEAK_TH, 32'(signed'(8'($urandom_range(0, 255)))));
                    write_reg(apt_pkg::REG_AGE_LIMIT, rand_time_span());
                    write_reg(apt_pkg::REG_RECENT_WIN, rand_time_span());
                    write_reg(apt_pkg::REG_WEIGHT, $urandom_range(0, 25600));
                    write_reg(apt_pkg::REG_MED_FLOOR, $urandom_range(0, 400000));
                    write_reg(apt_pkg::REG_MED_CEIL, $urandom_range(0, 400000));
                end
            endcase

            pool.delete();
            repeat ((p < 3) ? 80 : $urandom_range(4, 90)) pool = {pool, rand_addr()};
            clock_ms = $urandom();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                gap = 0;
                if (p < N_PHASES - 1 && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
                case ($urandom_range(0, 3))
                    0: clock_ms += $urandom_range(0, 20);
                    1, 2: clock_ms += $urandom_range(0, 2000);
                    default: clock_ms += (age_limit > 0 && $urandom_range(0, 1)) ?
                                         age_limit + 1 : $urandom();
                endcase
                send_frame(($urandom_range(0, 19) == 0) ? rand_addr()
                                                        : pool[$urandom_range(0, pool.size() - 1)],
                           8'($urandom_range(0, 255)), clock_ms, gap, r);
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
